@@ src/t2u64_pkg.sv @@
// ----------------------------------------------------------------------------
// t2u64_pkg
// Types and character constants for the text to unsigned 64-bit parser.
// ----------------------------------------------------------------------------
`default_nettype none

package t2u64_pkg;

   // One request: a string byte and its end marker.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_payload_type;

   // One response: the converted value and its overflow flag.
   typedef struct packed {
      logic [63:0] parsed_value;
      logic        range_error;
   } rsp_payload_type;

   // Parser phase within one string.
   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_STOPPED
   } phase_type;

   // Digit accumulation status.
   typedef enum logic [1:0] {
      DS_NONE,
      DS_OK,
      DS_OVER
   } status_type;

   localparam logic [5:0] BASE_RESET = 6'd10;
   localparam logic [5:0] RADIX_OCT  = 6'd8;
   localparam logic [5:0] RADIX_DEC  = 6'd10;
   localparam logic [5:0] RADIX_HEX  = 6'd16;
   localparam logic [5:0] RADIX_AUTO = 6'd0;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] UPPER_OFFSET = 8'h37;  // 'A' - 10
   localparam logic [7:0] LOWER_OFFSET = 8'h57;  // 'a' - 10
   localparam logic [7:0] NOT_DIGIT    = 8'hFF;

endpackage

`default_nettype wire

@@ src/text_to_unsigned64_parser.sv @@
// ----------------------------------------------------------------------------
// text_to_unsigned64_parser
// Streaming strtoull-style converter: one string byte per request, one
// response with the 64-bit value and a range error flag per string.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  req_      in         valid / stall    char_byte, end_of_text
//  rsp_      out        valid / stall    parsed_value, range_error
//  csr_      in         valid / ready    number_base (6 bits)
//
//  The parse state is updated at the edge that accepts each request, by one
//  64x6 multiply-add with an overflow check on the accumulator.
//  A request flagged end_of_text loads its response at that edge into the
//  output register, or into the skid register if the output one is held.
//  An output register plus a skid register decouple the two sides; req_stall
//  rises only when both hold undelivered responses.
//  Reset is synchronous; number_base returns to 10 and csr_ready is always 1.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_unsigned64_parser (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire t2u64_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output t2u64_pkg::rsp_payload_type   rsp_payload,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [5:0]                   csr_data
);

   // Configuration and parse state.
   logic [5:0]             number_base_ff;
   t2u64_pkg::phase_type   phase_ff, phase_in;
   logic [63:0]            accum_ff, accum_in;
   logic                   minus_ff, minus_in;
   logic [5:0]             radix_ff, radix_in;
   t2u64_pkg::status_type  status_ff, status_in;

   // Output register and skid register.
   logic                        out_valid_ff, out_valid_in;
   t2u64_pkg::rsp_payload_type  out_data_ff, out_data_in;
   logic                        skid_valid_ff, skid_valid_in;
   t2u64_pkg::rsp_payload_type  skid_data_ff, skid_data_in;

   // Combinational helpers.
   logic                        req_fire;
   logic                        out_fire;
   logic                        new_rsp;
   t2u64_pkg::rsp_payload_type  new_data;
   logic [7:0]                  chr;
   logic                        is_blank;
   logic [7:0]                  digit;
   logic                        start_num;
   logic                        do_feed;
   logic [69:0]                 product;
   logic [63:0]                 final_accum;
   t2u64_pkg::status_type       final_status;

   assign req_fire  = req_valid && !req_stall;
   assign out_fire  = out_valid_ff && !rsp_stall;
   assign new_rsp   = req_fire && req_payload.end_of_text;
   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign chr = req_payload.char_byte;

   // Character classes.
   always_comb begin
      is_blank = (chr == t2u64_pkg::CHAR_SPACE) ||
                 (chr >= t2u64_pkg::CHAR_TAB && chr <= t2u64_pkg::CHAR_CR);
      if (chr >= t2u64_pkg::CHAR_ZERO && chr <= t2u64_pkg::CHAR_NINE) begin
         digit = chr - t2u64_pkg::CHAR_ZERO;
      end else if (chr >= t2u64_pkg::CHAR_UPPER_A && chr <= t2u64_pkg::CHAR_UPPER_Z) begin
         digit = chr - t2u64_pkg::UPPER_OFFSET;
      end else if (chr >= t2u64_pkg::CHAR_LOWER_A && chr <= t2u64_pkg::CHAR_LOWER_Z) begin
         digit = chr - t2u64_pkg::LOWER_OFFSET;
      end else begin
         digit = t2u64_pkg::NOT_DIGIT;
      end
   end

   // Next parse state for the byte at the input.
   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      minus_in  = minus_ff;
      radix_in  = radix_ff;
      status_in = status_ff;
      start_num = 1'b0;
      do_feed   = 1'b0;

      unique case (phase_ff)
         t2u64_pkg::PH_SPACE: begin
            if (is_blank) begin
               phase_in = phase_ff;
            end else if (chr == t2u64_pkg::CHAR_MINUS) begin
               minus_in = 1'b1;
               phase_in = t2u64_pkg::PH_SIGNED;
            end else if (chr == t2u64_pkg::CHAR_PLUS) begin
               phase_in = t2u64_pkg::PH_SIGNED;
            end else begin
               start_num = 1'b1;
            end
         end
         t2u64_pkg::PH_SIGNED: begin
            start_num = 1'b1;
         end
         t2u64_pkg::PH_ZERO: begin
            phase_in = t2u64_pkg::PH_DIGITS;
            if (chr == t2u64_pkg::CHAR_LOWER_X || chr == t2u64_pkg::CHAR_UPPER_X) begin
               radix_in = t2u64_pkg::RADIX_HEX;
            end else begin
               do_feed = 1'b1;
            end
         end
         t2u64_pkg::PH_DIGITS: begin
            do_feed = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // First byte of the number: latch the radix, catch a leading zero.
      if (start_num) begin
         if ((number_base_ff == t2u64_pkg::RADIX_AUTO ||
              number_base_ff == t2u64_pkg::RADIX_HEX) && chr == t2u64_pkg::CHAR_ZERO) begin
            radix_in  = (number_base_ff == t2u64_pkg::RADIX_AUTO) ?
                        t2u64_pkg::RADIX_OCT : t2u64_pkg::RADIX_HEX;
            accum_in  = '0;
            status_in = t2u64_pkg::DS_OK;
            phase_in  = t2u64_pkg::PH_ZERO;
         end else begin
            radix_in = (number_base_ff == t2u64_pkg::RADIX_AUTO) ?
                       t2u64_pkg::RADIX_DEC : number_base_ff;
            phase_in = t2u64_pkg::PH_DIGITS;
            do_feed  = 1'b1;
         end
      end

      // Multiply-add; any set bit from bit 64 upward means the value left the range.
      product = ({6'd0, accum_ff} * {64'd0, radix_in}) + {62'd0, digit};

      if (do_feed) begin
         if (digit >= {2'b00, radix_in}) begin
            phase_in = t2u64_pkg::PH_STOPPED;
         end else if (status_ff != t2u64_pkg::DS_OVER) begin
            if (product[69:64] != 6'd0) begin
               status_in = t2u64_pkg::DS_OVER;
            end else begin
               accum_in  = product[63:0];
               status_in = t2u64_pkg::DS_OK;
            end
         end
      end

      // Response for a last byte, then back to the start of a string.
      final_accum  = accum_in;
      final_status = status_in;
      new_data.range_error = (final_status == t2u64_pkg::DS_OVER);
      if (final_status == t2u64_pkg::DS_OVER || !minus_in) begin
         new_data.parsed_value = final_accum;
      end else begin
         new_data.parsed_value = 64'd0 - final_accum;
      end

      if (req_payload.end_of_text) begin
         phase_in  = t2u64_pkg::PH_SPACE;
         accum_in  = '0;
         minus_in  = 1'b0;
         radix_in  = t2u64_pkg::RADIX_AUTO;
         status_in = t2u64_pkg::DS_NONE;
      end
   end

   // Output register and skid register steering.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_rsp) begin
         if (!out_valid_ff || out_fire) begin
            out_data_in  = new_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = new_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= t2u64_pkg::BASE_RESET;
         phase_ff       <= t2u64_pkg::PH_SPACE;
         accum_ff       <= '0;
         minus_ff       <= 1'b0;
         radix_ff       <= t2u64_pkg::RADIX_AUTO;
         status_ff      <= t2u64_pkg::DS_NONE;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            number_base_ff <= csr_data;
         end
         if (req_fire) begin
            phase_ff  <= phase_in;
            accum_ff  <= accum_in;
            minus_ff  <= minus_in;
            radix_ff  <= radix_in;
            status_ff <= status_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire
